[design/ped_pkg.sv]
`timescale 1ns / 1ps

package ped_pkg;

  // Fixed shape of the block
  localparam int LANES      = 4;
  localparam int COORD_BITS = 24;
  localparam int USED_BITS  = 3;
  localparam int SUM_BITS   = 64;
  localparam int DIST_BITS  = 32;

  // Derived widths
  localparam int MAG_BITS      = COORD_BITS + 1;
  localparam int LSUM_BITS     = SUM_BITS + $clog2(LANES + 1);
  localparam int IN_BITS       = 2 * LANES * COORD_BITS + USED_BITS;
  localparam int S_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS  = ((DIST_BITS + 7) / 8) * 8;
  localparam int REM_BITS      = DIST_BITS + 1;
  localparam int STEP_CNT_BITS = $clog2(DIST_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Control bits that travel with a chunk through the lane stage
  typedef struct packed {
    logic valid;
    logic last;
  } chunk_ctl_t;

  // Finished sum of one vector pair, handed to the root unit
  typedef struct packed {
    logic                valid;
    logic                clip;
    logic [SUM_BITS-1:0] sum;
  } fin_req_t;

endpackage

[design/ped_lane.sv]
`timescale 1ns / 1ps

module ped_lane (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            lane_on,
  input  ped_pkg::coord_t                 a,
  input  ped_pkg::coord_t                 b,
  output logic [ped_pkg::SUM_BITS-1:0]    sq,
  output logic                            big
);
  import ped_pkg::*;

  logic signed [MAG_BITS-1:0] diff;
  logic        [MAG_BITS-1:0] mag;
  logic        [SUM_BITS-1:0] mag_wide;
  logic        [DIST_BITS-1:0] mag_low;
  logic        [SUM_BITS-1:0] sq_c;
  logic                       big_c;

  // Difference and its magnitude; negating the most negative value still fits
  always_comb begin
    diff     = MAG_BITS'(a) - MAG_BITS'(b);
    mag      = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
    mag_wide = SUM_BITS'(mag);
    mag_low  = mag_wide[DIST_BITS-1:0];
    // a magnitude past 32 bits clips the sum outright
    big_c    = |mag_wide[SUM_BITS-1:DIST_BITS];
    sq_c     = SUM_BITS'(mag_low) * SUM_BITS'(mag_low);
  end

  // Registered square; an unused lane contributes nothing
  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= lane_on ? sq_c : '0;
      big <= lane_on & big_c;
    end
  end

endmodule

[design/ped_merge.sv]
`timescale 1ns / 1ps

module ped_merge (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  ped_pkg::chunk_ctl_t                        ctl,
  input  logic [ped_pkg::LANES-1:0][ped_pkg::SUM_BITS-1:0] sq,
  input  logic [ped_pkg::LANES-1:0]                  big,
  output ped_pkg::fin_req_t                          fin
);
  import ped_pkg::*;

  logic [LSUM_BITS-1:0] chunk_sum_c;
  logic [LSUM_BITS-1:0] chunk_sum;
  logic                 chunk_big;
  logic                 chunk_valid;
  logic                 chunk_last;

  logic [SUM_BITS-1:0]  acc;
  logic                 clip;
  logic [LSUM_BITS:0]   total;
  logic                 over;
  logic [SUM_BITS-1:0]  acc_next;
  logic                 clip_next;

  // Sum of the lane squares, wide enough never to wrap
  always_comb begin
    chunk_sum_c = '0;
    for (int i = 0; i < LANES; i++) begin
      chunk_sum_c = chunk_sum_c + LSUM_BITS'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chunk_sum <= chunk_sum_c;
      chunk_big <= |big;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_valid <= 1'b0;
      chunk_last  <= 1'b0;
    end else if (en) begin
      chunk_valid <= ctl.valid;
      chunk_last  <= ctl.last;
    end
  end

  // Saturating accumulate: squares are never negative, so clipping once
  // at the end of the chunk matches clipping lane by lane
  always_comb begin
    total     = (LSUM_BITS + 1)'(acc) + (LSUM_BITS + 1)'(chunk_sum);
    over      = chunk_big | (|total[LSUM_BITS:SUM_BITS]);
    acc_next  = over ? '1 : total[SUM_BITS-1:0];
    clip_next = clip | over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      clip      <= 1'b0;
      fin.valid <= 1'b0;
    end else if (en) begin
      fin.valid <= chunk_valid & chunk_last;
      // final sum of the pair; payload only
      fin.sum   <= acc_next;
      fin.clip  <= clip_next;
      if (chunk_valid) begin
        if (chunk_last) begin
          acc  <= '0;
          clip <= 1'b0;
        end else begin
          acc  <= acc_next;
          clip <= clip_next;
        end
      end
    end
  end

endmodule

[design/ped_sqrt.sv]
`timescale 1ns / 1ps

module ped_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  ped_pkg::fin_req_t                  fin,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ped_pkg::DIST_BITS-1:0]      out_root,
  output logic                               out_clip
);
  import ped_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [SUM_BITS-1:0]      x;
  logic [REM_BITS-1:0]      rem;
  logic [DIST_BITS-1:0]     root;
  logic                     clip;
  logic [STEP_CNT_BITS-1:0] cnt;

  logic [REM_BITS+1:0]      rem_t;
  logic [REM_BITS+1:0]      trial;
  logic                     ge;
  logic                     start;
  logic                     load_out;

  assign busy     = (state != S_IDLE);
  assign start    = fin.valid & (state == S_IDLE);
  assign load_out = (state == S_DONE) & (~out_valid | out_ready);

  // One root bit a step: bring down two bits, try root*4+1
  always_comb begin
    rem_t = {rem, x[SUM_BITS-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    ge    = (rem_t >= trial);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_RUN;
      S_RUN:  if (cnt == '0) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath of the iteration
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= fin.sum;
      rem  <= '0;
      root <= '0;
      clip <= fin.clip;
      cnt  <= STEP_CNT_BITS'(DIST_BITS - 1);
    end else if (state == S_RUN) begin
      x    <= x << 2;
      rem  <= ge ? REM_BITS'(rem_t - trial) : REM_BITS'(rem_t);
      root <= {root[DIST_BITS-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_root <= root;
      out_clip <= clip;
    end
  end

endmodule

[design/pairwise_euclidean_distance.sv]
`timescale 1ns / 1ps

// Euclidean distance of two points streamed as chunks of up to four coordinate
// pairs. Chunks are taken one per cycle unless stalled: each lane squares its
// difference, the lane squares are summed, then added to a 64-bit saturating
// accumulator. A chunk marked tlast closes the pair: its sum goes to a
// bit-serial square root that produces one root bit per cycle. Chunks of the
// next pair keep flowing meanwhile; only a second last chunk waits, while the
// root unit is still busy with the previous result or that result has not yet
// been taken. The distance is floor(sqrt), 4294967295 with the saturated flag
// set if the sum clipped.
module pairwise_euclidean_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // coord_a0..a3, coord_b0..b3, lanes_used, zero fill
  input  logic [ped_pkg::S_TDATA_BITS-1:0]    s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // distance
  output logic [ped_pkg::M_TDATA_BITS-1:0]    m_tdata,
  // saturated
  output logic                                m_tuser
);
  import ped_pkg::*;

  logic [USED_BITS-1:0]               lanes_used;
  logic                               en;
  logic                               take;
  chunk_ctl_t                         ctl;
  logic [LANES-1:0][SUM_BITS-1:0]     sq;
  logic [LANES-1:0]                   big;
  fin_req_t                           fin;
  logic                               root_busy;
  logic [DIST_BITS-1:0]               root;

  // The whole chunk path stalls only when a finished sum cannot enter the root unit
  assign en         = ~(fin.valid & root_busy);
  assign s_tready   = en;
  assign take       = s_tvalid & en;
  assign lanes_used = s_tdata[2*LANES*COORD_BITS +: USED_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
      ctl.last  <= 1'b0;
    end else if (en) begin
      ctl.valid <= take;
      ctl.last  <= s_tlast;
    end
  end

  // Lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ped_lane u_lane (
      .clk     (clk),
      .en      (en),
      .lane_on (int'(lanes_used) > i),
      .a       (coord_t'(s_tdata[i*COORD_BITS +: COORD_BITS])),
      .b       (coord_t'(s_tdata[(LANES+i)*COORD_BITS +: COORD_BITS])),
      .sq      (sq[i]),
      .big     (big[i])
    );
  end

  ped_merge u_merge (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .ctl (ctl),
    .sq  (sq),
    .big (big),
    .fin (fin)
  );

  ped_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .busy      (root_busy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_root  (root),
    .out_clip  (m_tuser)
  );

  assign m_tdata = M_TDATA_BITS'(root);

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ped_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 185;
  localparam int USED_LSB     = 2 * LANES * COORD_BITS;

  typedef logic [S_TDATA_BITS-1:0] chunk_word_t;

  // One expected result: distance and the clip flag
  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 sat;
  } distance_t;

  // Tracks the running sum of squares and queues the distances it predicts
  class distance_tracker;
    logic [SUM_BITS-1:0] sum_sq;
    logic                clipped;
    distance_t           due_distances[$];
    int                  mismatches;

    function new();
      sum_sq      = '0;
      clipped     = 1'b0;
      mismatches  = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function logic [DIST_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] x);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = DIST_BITS - 1; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= x) r = t;
      end
      return r[DIST_BITS-1:0];
    endfunction

    // Fold one accepted chunk into the sum; a last chunk closes the pair
    function void take_chunk(input chunk_word_t word, input logic last);
      int unsigned         n;
      longint              av;
      longint              bv;
      longint              d;
      logic [63:0]         sq;
      logic [SUM_BITS:0]   tot;
      distance_t           res;
      n = 32'(word[USED_LSB +: USED_BITS]);
      if (n > LANES) n = LANES;
      for (int i = 0; i < n; i++) begin
        av  = $signed(word[i * COORD_BITS +: COORD_BITS]);
        bv  = $signed(word[(LANES + i) * COORD_BITS +: COORD_BITS]);
        d   = av - bv;
        if (d < 0) d = -d;
        sq  = d * d;
        tot = {1'b0, sum_sq} + {1'b0, sq};
        if (tot[SUM_BITS]) begin
          sum_sq  = '1;
          clipped = 1'b1;
        end else begin
          sum_sq = tot[SUM_BITS-1:0];
        end
      end
      if (last) begin
        res.distance = floor_root(sum_sq);
        res.sat      = clipped;
        due_distances.push_back(res);
        sum_sq  = '0;
        clipped = 1'b0;
      end
    endfunction

    task check_distance(input logic [M_TDATA_BITS-1:0] data, input logic user);
      distance_t want;
      if (due_distances.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance=%0d sat=%0b",
                                  data[DIST_BITS-1:0], user));
      end else begin
        want = due_distances.pop_front();
        if (data[DIST_BITS-1:0] !== want.distance)
          report_mismatch($sformatf("distance got %0d want %0d", data[DIST_BITS-1:0],
                                    want.distance));
        if (user !== want.sat)
          report_mismatch($sformatf("saturated got %0b want %0b", user, want.sat));
      end
    endtask

    function int pending();
      return due_distances.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata;
  logic                    s_tlast;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic                    m_tuser;

  distance_tracker tracker = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  cycles = 0;
  int  items_sent;

  pairwise_euclidean_distance dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("pairwise_euclidean_distance regression: fail");
      $finish;
    end
  end

  // Accepted requests and results
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.take_chunk(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) tracker.check_distance(m_tdata, m_tuser);
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic chunk_word_t pack_chunk(input logic [LANES*COORD_BITS-1:0] a,
                                             input logic [LANES*COORD_BITS-1:0] b,
                                             input logic [USED_BITS-1:0] used);
    chunk_word_t w;
    w = '0;
    w[0 +: LANES*COORD_BITS]             = a;
    w[LANES*COORD_BITS +: LANES*COORD_BITS] = b;
    w[USED_LSB +: USED_BITS]             = used;
    return w;
  endfunction

  // Mostly uniform, sometimes an extreme value
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(15))
      0: return {1'b1, {(COORD_BITS-1){1'b0}}};
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [USED_BITS-1:0] pick_used();
    case ($urandom_range(15))
      0: return 3'd0;
      1: return 3'(LANES + 1 + $urandom_range(2));
      default: return 3'(1 + $urandom_range(LANES - 1));
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic offer_chunk(input chunk_word_t word, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_random_pair(input int chunks);
    logic [LANES*COORD_BITS-1:0] a;
    logic [LANES*COORD_BITS-1:0] b;
    for (int k = 0; k < chunks; k++) begin
      for (int i = 0; i < LANES; i++) begin
        a[i*COORD_BITS +: COORD_BITS] = pick_coord();
        b[i*COORD_BITS +: COORD_BITS] = pick_coord();
      end
      offer_chunk(pack_chunk(a, b, pick_used()), k == chunks - 1);
    end
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int items);
    int target;
    target = items_sent + items;
    while (items_sent < target)
      send_random_pair(($urandom_range(7) == 0) ? 5 + $urandom_range(5)
                                                : 1 + $urandom_range(3));
  endtask

  localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  initial begin
    logic [LANES*COORD_BITS-1:0] hi;
    logic [LANES*COORD_BITS-1:0] lo;
    logic [LANES*COORD_BITS-1:0] ra;
    hi = {LANES{C_MAX}};
    lo = {LANES{C_MIN}};
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, widest differences both ways, empty and oversized chunks
    offer_chunk(pack_chunk('0, '0, 3'd4), 1'b1);
    offer_chunk(pack_chunk(hi, lo, 3'd4), 1'b1);
    offer_chunk(pack_chunk(lo, hi, 3'd1), 1'b1);
    offer_chunk(pack_chunk(hi, lo, 3'd0), 1'b1);
    offer_chunk(pack_chunk(hi, lo, 3'd0), 1'b0);
    offer_chunk(pack_chunk(hi, '0, 3'd2), 1'b1);
    offer_chunk(pack_chunk(hi, lo, 3'd5), 1'b1);
    offer_chunk(pack_chunk(lo, hi, 3'd6), 1'b1);
    offer_chunk(pack_chunk(hi, '0, 3'd7), 1'b1);
    // 3-4-5 triangle split over two chunks
    offer_chunk(pack_chunk({{(LANES-1)*COORD_BITS{1'b0}}, 24'd3}, '0, 3'd1), 1'b0);
    offer_chunk(pack_chunk('0, {{(LANES-1)*COORD_BITS{1'b0}}, 24'd4}, 3'd1), 1'b1);
    // identical points
    ra = {$urandom, $urandom, $urandom};
    offer_chunk(pack_chunk(ra, ra, 3'd4), 1'b1);
    send_random_pair(3);
    s_tvalid <= 1'b0;
    wait_drained();

    // Random, sender seldom idle, receiver often stalled
    send_idle_pct = 8;
    recv_idle_pct = 68;
    random_phase(PHASE_ITEMS);
    s_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // Random, the other way round
    send_idle_pct = 68;
    recv_idle_pct = 8;
    random_phase(PHASE_ITEMS);

    // No idling; receiver holds off while short pairs keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    for (int k = 0; k < 12; k++) send_random_pair(1);
    random_phase(PHASE_ITEMS);
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never came", tracker.pending()));
    if (tracker.mismatches == 0) begin
      $display("pairwise_euclidean_distance regression: pass");
    end else begin
      $display("pairwise_euclidean_distance regression: fail");
    end
    $finish;
  end

endmodule
